@@ rtl/lrmc_pkg.sv @@
// ----------------------------------------------------------------------------
// lrmc_pkg
// Shared types and constants for the LRU ring message cache.
// ----------------------------------------------------------------------------
package lrmc_pkg;

  localparam int unsigned SLOTS_DEF = 16;

  localparam int unsigned ID_W   = 31;
  localparam int unsigned PAY_W  = 32;
  localparam int unsigned HELD_W = 5;
  localparam int unsigned VICT_W = 4;

  localparam logic CMD_LOOKUP = 1'b0;
  localparam logic CMD_INSERT = 1'b1;

  localparam logic POL_RANDOM = 1'b0;
  localparam logic POL_LRU    = 1'b1;

  typedef struct packed {
    logic              cmd;
    logic [ID_W-1:0]   msg_id;
    logic [PAY_W-1:0]  entry_payload;
    logic              policy;
    logic [VICT_W-1:0] victim_slot;
  } in_t;

  typedef struct packed {
    logic              hit;
    logic [PAY_W-1:0]  found_payload;
    logic [HELD_W-1:0] entries_held;
  } out_t;

  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [PAY_W-1:0] payload;
  } entry_t;

  // finished result handed from the controller to the output stage
  typedef struct packed {
    logic valid;
    out_t data;
  } rsp_t;

endpackage

@@ rtl/lrmc_mem.sv @@
// ----------------------------------------------------------------------------
// lrmc_mem
// Entry storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module lrmc_mem
  import lrmc_pkg::*;
#(
  parameter int unsigned SLOTS = SLOTS_DEF,
  localparam int unsigned AW   = $clog2(SLOTS)
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  entry_t        wdata_i,
  input  logic [AW-1:0] raddr_i,
  output entry_t        rdata_o
);

  entry_t mem_q [SLOTS];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/lrmc_ctrl.sv @@
// ----------------------------------------------------------------------------
// lrmc_ctrl
// Ring pointers and the sequencer that walks the entry memory for search,
// move-to-rear shift and insert.
// ----------------------------------------------------------------------------
module lrmc_ctrl
  import lrmc_pkg::*;
#(
  parameter int unsigned SLOTS = SLOTS_DEF,
  localparam int unsigned AW   = $clog2(SLOTS),
  localparam int unsigned CW   = $clog2(SLOTS + 1)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  in_t           in_data_i,
  output rsp_t          rsp_o,
  input  logic          rsp_take_i,
  output logic          mem_we_o,
  output logic [AW-1:0] mem_waddr_o,
  output entry_t        mem_wdata_o,
  output logic [AW-1:0] mem_raddr_o,
  input  entry_t        mem_rdata_i
);

  localparam int unsigned MW        = CW + VICT_W;
  localparam int unsigned MOD_STEPS = ((2 ** VICT_W) - 1) / SLOTS;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_SHIFT,
    ST_FINAL,
    ST_RESP
  } state_e;

  state_e          state_q, state_d;
  logic [AW-1:0]   oldest_q, oldest_d;
  logic [AW-1:0]   newest_q, newest_d;
  logic [CW-1:0]   count_q, count_d;
  logic [CW-1:0]   issued_q, issued_d;
  logic [AW-1:0]   ptr_q, ptr_d;
  logic [AW-1:0]   cmp_q, cmp_d;
  logic [AW-1:0]   j_q, j_d;
  logic [AW-1:0]   rd_q, rd_d;
  logic [ID_W-1:0] look_id_q, look_id_d;
  entry_t          keep_q, keep_d;
  out_t            res_q, res_d;

  logic [MW-1:0]   vmod;
  logic [AW-1:0]   victim_idx;
  logic            full;
  logic            in_acc;

  function automatic logic [AW-1:0] ring_next(input logic [AW-1:0] x);
    logic [AW-1:0] r;
    if (x == AW'(SLOTS - 1)) r = '0;
    else                     r = x + 1'b1;
    return r;
  endfunction

  // victim_slot modulo SLOTS by repeated subtract; no steps once SLOTS > 15
  always_comb begin
    vmod = MW'(in_data_i.victim_slot);
    for (int k = 0; k < MOD_STEPS; k++) begin
      if (vmod >= MW'(SLOTS)) vmod = vmod - MW'(SLOTS);
    end
    victim_idx = AW'(vmod);
  end

  assign full       = (count_q == CW'(SLOTS));
  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;

  always_comb begin
    state_d     = state_q;
    oldest_d    = oldest_q;
    newest_d    = newest_q;
    count_d     = count_q;
    issued_d    = issued_q;
    ptr_d       = ptr_q;
    cmp_d       = cmp_q;
    j_d         = j_q;
    rd_d        = rd_q;
    look_id_d   = look_id_q;
    keep_d      = keep_q;
    res_d       = res_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = newest_q;
    mem_wdata_o = keep_q;
    mem_raddr_o = ptr_q;

    unique case (state_q)
      ST_IDLE: begin
        mem_raddr_o = oldest_q;
        if (in_acc) begin
          if (in_data_i.cmd == CMD_INSERT) begin
            mem_we_o    = 1'b1;
            mem_wdata_o = '{id: in_data_i.msg_id, payload: in_data_i.entry_payload};
            if (full) begin
              if (in_data_i.policy == POL_LRU) begin
                mem_waddr_o = oldest_q;
                oldest_d    = ring_next(oldest_q);
                newest_d    = oldest_q;
              end else begin
                mem_waddr_o = victim_idx;
              end
            end else begin
              mem_waddr_o = ring_next(newest_q);
              newest_d    = ring_next(newest_q);
              count_d     = count_q + 1'b1;
            end
            res_d   = '{hit: 1'b0, found_payload: '0, entries_held: HELD_W'(count_d)};
            state_d = ST_RESP;
          end else begin
            look_id_d = in_data_i.msg_id;
            if (count_q == '0) begin
              res_d   = '{hit: 1'b0, found_payload: '0, entries_held: HELD_W'(count_q)};
              state_d = ST_RESP;
            end else begin
              cmp_d    = oldest_q;
              ptr_d    = ring_next(oldest_q);
              issued_d = CW'(1);
              state_d  = ST_SEARCH;
            end
          end
        end
      end

      // read data holds the entry at cmp_q; next read is issued in the same cycle
      ST_SEARCH: begin
        if (mem_rdata_i.id == look_id_q) begin
          keep_d = mem_rdata_i;
          if (cmp_q == newest_q) begin
            state_d = ST_FINAL;
          end else begin
            j_d         = cmp_q;
            rd_d        = ring_next(cmp_q);
            mem_raddr_o = ring_next(cmp_q);
            state_d     = ST_SHIFT;
          end
        end else if (issued_q == count_q) begin
          res_d   = '{hit: 1'b0, found_payload: '0, entries_held: HELD_W'(count_q)};
          state_d = ST_RESP;
        end else begin
          mem_raddr_o = ptr_q;
          cmp_d       = ptr_q;
          ptr_d       = ring_next(ptr_q);
          issued_d    = issued_q + 1'b1;
        end
      end

      // entry at rd_q moves down into j_q, one slot per cycle
      ST_SHIFT: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = j_q;
        mem_wdata_o = mem_rdata_i;
        j_d         = rd_q;
        if (rd_q == newest_q) begin
          state_d = ST_FINAL;
        end else begin
          mem_raddr_o = ring_next(rd_q);
          rd_d        = ring_next(rd_q);
        end
      end

      ST_FINAL: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = newest_q;
        mem_wdata_o = keep_q;
        res_d       = '{hit: 1'b1, found_payload: keep_q.payload,
                        entries_held: HELD_W'(count_q)};
        state_d     = ST_RESP;
      end

      ST_RESP: begin
        if (rsp_take_i) state_d = ST_IDLE;
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      oldest_q  <= '0;
      newest_q  <= AW'(SLOTS - 1);
      count_q   <= '0;
      issued_q  <= '0;
      ptr_q     <= '0;
      cmp_q     <= '0;
      j_q       <= '0;
      rd_q      <= '0;
      look_id_q <= '0;
      keep_q    <= '0;
      res_q     <= '0;
    end else begin
      state_q   <= state_d;
      oldest_q  <= oldest_d;
      newest_q  <= newest_d;
      count_q   <= count_d;
      issued_q  <= issued_d;
      ptr_q     <= ptr_d;
      cmp_q     <= cmp_d;
      j_q       <= j_d;
      rd_q      <= rd_d;
      look_id_q <= look_id_d;
      keep_q    <= keep_d;
      res_q     <= res_d;
    end
  end

  assign rsp_o.valid = (state_q == ST_RESP);
  assign rsp_o.data  = res_q;

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(SLOTS))
    else $error("held count above slot count");

  a_lookup_keeps_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_data_i.cmd == CMD_LOOKUP) |=> $stable(count_q))
    else $error("lookup changed the held count");

  a_shift_not_newest: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SHIFT) |-> (j_q != newest_q))
    else $error("shift writes the newest slot");

  a_search_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SEARCH) |-> (count_q != '0 && issued_q <= count_q))
    else $error("search walked past the held entries");

  a_pointers_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SEARCH || state_q == ST_SHIFT) |=>
      ($stable(oldest_q) && $stable(newest_q)))
    else $error("ring pointers moved during a lookup");
`endif

endmodule

@@ rtl/lru_ring_message_cache_top.sv @@
// ----------------------------------------------------------------------------
// lru_ring_message_cache_top
// Fully associative message cache kept as a ring, with LRU move-to-rear.
// ----------------------------------------------------------------------------
// One transaction is in work at a time; the result sits in an output register
// so the next transaction can enter while it waits. A lookup walks the held
// entries from oldest to newest at one entry per cycle through the entry
// memory read port, then on a hit moves each later entry down one slot per
// cycle and writes the hit entry to the newest slot. A miss ends once every
// held entry has been read. No clearing pass after reset.
// ----------------------------------------------------------------------------
module lru_ring_message_cache_top
  import lrmc_pkg::*;
#(
  parameter int unsigned SLOTS = SLOTS_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_data_o
);

  localparam int unsigned AW = $clog2(SLOTS);

  rsp_t          rsp;
  logic          rsp_take;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [AW-1:0] mem_raddr;
  entry_t        mem_wdata;
  entry_t        mem_rdata;

  logic          out_valid_q;
  out_t          out_q;

  lrmc_ctrl #(
    .SLOTS (SLOTS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .rsp_o       (rsp),
    .rsp_take_i  (rsp_take),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  lrmc_mem #(
    .SLOTS (SLOTS)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // output register loads when empty or being drained this cycle
  assign rsp_take = rsp.valid && (!out_valid_q || !out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else if (rsp_take) begin
      out_valid_q <= 1'b1;
      out_q       <= rsp.data;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
